// ===== rtl/mfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_pkg: shared types and constants of the frame buffer drawing block
// Panel geometry, field widths, command codes and the box types that pass
// between the sequencer and the clipping unit.
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam int PANEL_WIDTH  = 296;
  localparam int PANEL_HEIGHT = 128;
  localparam int ROW_BYTES    = 16;
  localparam int FRAME_BYTES  = PANEL_WIDTH * ROW_BYTES;

  // Pixels with y at or beyond this limit are never stored.
  localparam int Y_LIMIT = (PANEL_HEIGHT < ROW_BYTES * 8) ? PANEL_HEIGHT : ROW_BYTES * 8;

  localparam int ACT_W  = 3;
  localparam int POS_W  = 11;
  localparam int SPAN_W = 10;
  localparam int RADR_W = 13;
  localparam int DATA_W = 8;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int XW = $clog2(PANEL_WIDTH + 1);
  localparam int YW = $clog2(Y_LIMIT + 1);
  localparam int CW = POS_W + 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR   = 3'd0,
    ACT_PIXEL   = 3'd1,
    ACT_HLINE   = 3'd2,
    ACT_VLINE   = 3'd3,
    ACT_OUTLINE = 3'd4,
    ACT_FILL    = 3'd5,
    ACT_READ    = 3'd6,
    ACT_NOP     = 3'd7
  } action_e;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [SPAN_W-1:0]    w;
    logic [SPAN_W-1:0]    h;
  } box_t;

  typedef struct packed {
    logic          empty;
    logic [XW-1:0] x0;
    logic [XW-1:0] x1;
    logic [YW-1:0] y0;
    logic [YW-1:0] y1;
  } clip_t;

endpackage

// ===== rtl/mfb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_cmd_if / mfb_rsp_if: command and response channels
// Valid/ready channels that carry one drawing command and one read byte.
// ----------------------------------------------------------------------------
interface mfb_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [mfb_pkg::ACT_W-1:0]           action;
  logic signed [mfb_pkg::POS_W-1:0]    pos_x;
  logic signed [mfb_pkg::POS_W-1:0]    pos_y;
  logic [mfb_pkg::SPAN_W-1:0]          span_w;
  logic [mfb_pkg::SPAN_W-1:0]          span_h;
  logic                                color;
  logic [mfb_pkg::RADR_W-1:0]          read_addr;

  modport source (output valid, action, pos_x, pos_y, span_w, span_h, color, read_addr,
                  input ready);
  modport sink (input valid, action, pos_x, pos_y, span_w, span_h, color, read_addr,
                output ready);
endinterface

interface mfb_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [mfb_pkg::DATA_W-1:0]  read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// ===== rtl/mfb_box_clip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_box_clip: box clipping unit
// Clips one box [x, x+w) by [y, y+h) to the stored panel area and flags
// boxes that cover no pixel.
// ----------------------------------------------------------------------------
module mfb_box_clip (
  input  mfb_pkg::box_t  box_i,
  output mfb_pkg::clip_t clip_o
);
  import mfb_pkg::*;

  localparam logic signed [CW-1:0] XLIM = CW'(PANEL_WIDTH);
  localparam logic signed [CW-1:0] YLIM = CW'(Y_LIMIT);

  logic signed [CW-1:0] w_s, h_s, xe, ye, x0s, x1s, y0s, y1s;

  always_comb begin
    w_s = $signed({{(CW-SPAN_W){1'b0}}, box_i.w});
    h_s = $signed({{(CW-SPAN_W){1'b0}}, box_i.h});
    xe  = box_i.x + w_s;
    ye  = box_i.y + h_s;
    x0s = (box_i.x < 0) ? '0 : box_i.x;
    y0s = (box_i.y < 0) ? '0 : box_i.y;
    x1s = (xe > XLIM) ? XLIM : xe;
    y1s = (ye > YLIM) ? YLIM : ye;
    clip_o.empty = (box_i.w == '0) || (box_i.h == '0) || (x0s >= x1s) || (y0s >= y1s);
    clip_o.x0 = x0s[XW-1:0];
    clip_o.x1 = x1s[XW-1:0];
    clip_o.y0 = y0s[YW-1:0];
    clip_o.y1 = y1s[YW-1:0];
  end

endmodule

// ===== rtl/mono_framebuffer_rect_draw.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_rect_draw: monochrome frame buffer with rectangle drawing
// Holds the rotated 1-bit frame memory of a landscape panel and draws
// pixels, lines, outlines and filled rectangles into it.
// ----------------------------------------------------------------------------
// Commands arrive on cmd_i, one beat per command. Every command returns
// exactly one beat on rsp_o: the addressed frame byte for a read inside
// the frame, zero for all other commands. The block handles one command
// at a time and keeps cmd_i.ready low until that command's response has
// been loaded into the output register; the next beat can be taken in the
// cycle after that. Steps: a clear writes one byte per cycle and then
// answers. A read issues its frame memory read and then answers. Drawing
// commands clip each box in turn (one for a pixel, line or fill, four for
// an outline), read and then write the frame memory for every visible
// pixel, pass through a step per box that picks the next box or ends, and
// then answer.
// After reset the block sweeps the frame memory to zero, one byte per
// cycle, with cmd_i.ready low until the sweep ends; this sweep sends no beat.
// If the receiver stalls rsp_o, the response waits in its register, and
// a following command finishes its work and then holds until the earlier
// beat is taken.
// ----------------------------------------------------------------------------
module mono_framebuffer_rect_draw (
  input  logic clk_i,
  input  logic rst_ni,
  mfb_cmd_if.sink   cmd_i,
  mfb_rsp_if.source rsp_o
);
  import mfb_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CLEAR  = 4'd1;
  localparam logic [3:0] ST_SETUP  = 4'd2;
  localparam logic [3:0] ST_PIX_RD = 4'd3;
  localparam logic [3:0] ST_PIX_WR = 4'd4;
  localparam logic [3:0] ST_NEXT   = 4'd5;
  localparam logic [3:0] ST_RD_ISS = 4'd6;
  localparam logic [3:0] ST_DONE   = 4'd7;

  logic [3:0] state_q, state_d;

  action_e                  act_q;
  logic signed [POS_W-1:0]  px_q, py_q;
  logic [SPAN_W-1:0]        sw_q, sh_q;
  logic                     color_q;
  logic [RADR_W-1:0]        raddr_q;

  logic                     fill_white_q, fill_white_d;
  logic                     respond_q, respond_d;
  logic [AW-1:0]            clr_q, clr_d;
  logic [1:0]               box_q, box_d;
  logic [XW-1:0]            x0_q, x0_d, x1_q, x1_d, cx_q, cx_d;
  logic [YW-1:0]            y1_q, y1_d, cy_q, cy_d;

  logic                     rsp_valid_q, rsp_valid_d;
  logic [DATA_W-1:0]        rsp_data_q, rsp_data_d;

  logic [DATA_W-1:0]        mem [FRAME_BYTES];
  logic [DATA_W-1:0]        rdata_q;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr, pix_addr;
  logic [DATA_W-1:0]        mem_wdata, pix_mask;

  box_t                     box;
  clip_t                    clip;
  logic signed [CW-1:0]     bx, by;
  logic                     cmd_acc, rd_ok, last_box;
  logic [XW-1:0]            row;

  assign cmd_acc = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.read_data = rsp_data_q;

  assign rd_ok    = (raddr_q < RADR_W'(FRAME_BYTES));
  assign last_box = (act_q == ACT_OUTLINE) ? (box_q == 2'd3) : 1'b1;

  // Each drawing command reduces to one or more boxes; an outline is four lines.
  always_comb begin
    bx = CW'(px_q);
    by = CW'(py_q);
    box.x = bx;
    box.y = by;
    box.w = sw_q;
    box.h = sh_q;
    case (act_q)
      ACT_PIXEL: begin
        box.w = SPAN_W'(1);
        box.h = SPAN_W'(1);
      end
      ACT_HLINE: box.h = SPAN_W'(1);
      ACT_VLINE: box.w = SPAN_W'(1);
      ACT_OUTLINE: begin
        case (box_q)
          2'd0: box.h = SPAN_W'(1);
          2'd1: begin
            box.y = by + $signed({{(CW-SPAN_W){1'b0}}, sh_q}) - CW'(1);
            box.h = SPAN_W'(1);
          end
          2'd2: box.w = SPAN_W'(1);
          default: begin
            box.x = bx + $signed({{(CW-SPAN_W){1'b0}}, sw_q}) - CW'(1);
            box.w = SPAN_W'(1);
          end
        endcase
      end
      default: ;
    endcase
  end

  mfb_box_clip u_clip (
    .box_i  (box),
    .clip_o (clip)
  );

  assign row      = XW'(PANEL_WIDTH - 1) - cx_q;
  assign pix_addr = AW'(AW'(row) * AW'(ROW_BYTES)) + AW'(cy_q[YW-1:3]);
  assign pix_mask = 8'h80 >> cy_q[2:0];

  always_comb begin
    state_d      = state_q;
    fill_white_d = fill_white_q;
    respond_d    = respond_q;
    clr_d        = clr_q;
    box_d        = box_q;
    x0_d         = x0_q;
    x1_d         = x1_q;
    y1_d         = y1_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_data_d   = rsp_data_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = pix_addr;
    mem_wdata    = color_q ? (rdata_q | pix_mask) : (rdata_q & ~pix_mask);
    mem_raddr    = pix_addr;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_acc) begin
          respond_d = 1'b1;
          box_d     = 2'd0;
          clr_d     = '0;
          unique case (action_e'(cmd_i.action)) inside
            ACT_CLEAR: begin
              fill_white_d = cmd_i.color;
              state_d      = ST_CLEAR;
            end
            ACT_PIXEL, ACT_HLINE, ACT_VLINE, ACT_OUTLINE, ACT_FILL: state_d = ST_SETUP;
            ACT_READ: state_d = ST_RD_ISS;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = {DATA_W{fill_white_q}};
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(FRAME_BYTES - 1)) begin
          state_d = respond_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_SETUP: begin
        x0_d = clip.x0;
        x1_d = clip.x1;
        y1_d = clip.y1;
        cx_d = clip.x0;
        cy_d = clip.y0;
        state_d = clip.empty ? ST_NEXT : ST_PIX_RD;
      end
      ST_PIX_RD: begin
        mem_re  = 1'b1;
        state_d = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        mem_we = 1'b1;
        if ({1'b0, cx_q} + (XW+1)'(1) < {1'b0, x1_q}) begin
          cx_d    = cx_q + XW'(1);
          state_d = ST_PIX_RD;
        end else begin
          cx_d = x0_q;
          if ({1'b0, cy_q} + (YW+1)'(1) < {1'b0, y1_q}) begin
            cy_d    = cy_q + YW'(1);
            state_d = ST_PIX_RD;
          end else begin
            state_d = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        if (last_box) begin
          state_d = ST_DONE;
        end else begin
          box_d   = box_q + 2'd1;
          state_d = ST_SETUP;
        end
      end
      ST_RD_ISS: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(raddr_q);
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_data_d  = (act_q == ACT_READ && rd_ok) ? rdata_q : '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      fill_white_q <= 1'b0;
      respond_q    <= 1'b0;
      clr_q        <= '0;
      box_q        <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_white_q <= fill_white_d;
      respond_q    <= respond_d;
      clr_q        <= clr_d;
      box_q        <= box_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      act_q   <= action_e'(cmd_i.action);
      px_q    <= cmd_i.pos_x;
      py_q    <= cmd_i.pos_y;
      sw_q    <= cmd_i.span_w;
      sh_q    <= cmd_i.span_h;
      color_q <= cmd_i.color;
      raddr_q <= cmd_i.read_addr;
    end
    x0_q       <= x0_d;
    x1_q       <= x1_d;
    y1_q       <= y1_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    rsp_data_q <= rsp_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_PIX_WR))
    else $error("frame memory written outside a clear or pixel write");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIX_WR) |-> $past(state_q) == ST_PIX_RD)
    else $error("pixel write not preceded by its read");

  a_pix_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIX_RD || state_q == ST_PIX_WR) |->
      (cx_q < x1_q && cy_q < y1_q && cx_q < XW'(PANEL_WIDTH)))
    else $error("pixel counter left the clipped box");

  a_rsp_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_IDLE) |=> rsp_valid_q)
    else $error("finished command produced no response beat");

endmodule
